// ===== sv/lsb_pixel_stego_embed_extract_top_assert.svh =====
// Assertion helpers for the steganography block. The using scope provides i_clk and i_rst_n.
`ifndef LSB_PIXEL_STEGO_EMBED_EXTRACT_TOP_ASSERT_SVH
`define LSB_PIXEL_STEGO_EMBED_EXTRACT_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LSBSE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LSBSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lsbse_pkg.sv =====
package lsbse_pkg;

    localparam int MSG_DEPTH  = 256;
    localparam int MSG_AW     = $clog2(MSG_DEPTH);
    localparam int LEN_W      = MSG_AW + 1;
    localparam int POS_W      = LEN_W + 3;
    localparam int BANK_DEPTH = MSG_DEPTH / 2;
    localparam int BANK_AW    = MSG_AW - 1;
    localparam logic [7:0] TERM_RESET = 8'd59;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;
    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_BYTE    = 1'b1;
    localparam logic REG_MODE     = 1'b0;
    localparam logic REG_TERM     = 1'b1;

    // Request to the two message banks: even bytes in one, odd bytes in the other.
    typedef struct packed {
        logic               we_even;
        logic               we_odd;
        logic [BANK_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic               re;
        logic [BANK_AW-1:0] raddr_even;
        logic [BANK_AW-1:0] raddr_odd;
    } t_ram_req;

    // What stage one needs to finish a result.
    typedef struct packed {
        logic       kind;
        logic [2:0] en;
        logic [2:0] off;
        logic       idx0;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] data;
        logic       fin;
    } t_s1;

    typedef struct packed {
        logic       kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] data;
        logic       fin;
    } t_res;

endpackage

// ===== sv/lsbse_ram.sv =====
module lsbse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/lsbse_front.sv =====
module lsbse_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_cmd,
    input  logic [7:0]        i_msg_byte,
    input  logic [7:0]        i_pix_red,
    input  logic [7:0]        i_pix_green,
    input  logic [7:0]        i_pix_blue,
    input  logic              i_frame_start,
    input  logic              i_mode,
    input  logic [7:0]        i_term,
    output lsbse_pkg::t_s1     o_s1,
    output logic              o_emit,
    output lsbse_pkg::t_ram_req o_ram
);
    import lsbse_pkg::*;

    logic [LEN_W-1:0] r_len, n_len;
    logic             r_closed, n_closed;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_acc, n_acc;
    logic [2:0]       r_nb, n_nb;
    logic             r_done, n_done;

    t_cmd             cmd;
    logic [POS_W-1:0] pos0, total, q, new_pos;
    logic [2:0]       en;
    logic [1:0]       cnt;
    logic [LEN_W-1:0] idx, idx_p1;
    logic             can_load;

    logic [7:0]       x_acc;
    logic [3:0]       x_cnt;
    logic             x_done, x_emit, x_fin;
    logic [7:0]       x_data;
    logic [2:0]       pix_bits;

    assign cmd = t_cmd'(i_cmd);

    // Embed addressing and bit position.
    always_comb begin
        pos0  = i_frame_start ? '0 : r_pos;
        total = {r_len, 3'b000};
        for (int k = 0; k < 3; k++) begin
            q     = pos0 + POS_W'(k);
            en[k] = (q < total);
        end
        cnt     = 2'(en[0]) + 2'(en[1]) + 2'(en[2]);
        new_pos = pos0 + POS_W'(cnt);
        idx     = pos0[POS_W-1:3];
        idx_p1  = idx + LEN_W'(1);
    end

    // Extraction: up to three bits gathered, at most one byte completes.
    always_comb begin
        pix_bits = {i_pix_blue[0], i_pix_green[0], i_pix_red[0]};
        x_acc    = i_frame_start ? 8'd0 : r_acc;
        x_cnt    = i_frame_start ? 4'd0 : {1'b0, r_nb};
        x_done   = i_frame_start ? 1'b0 : r_done;
        x_emit   = 1'b0;
        x_fin    = 1'b0;
        x_data   = 8'd0;
        for (int k = 0; k < 3; k++) begin
            if (!x_done) begin
                x_acc = x_acc | (8'(pix_bits[k]) << x_cnt[2:0]);
                x_cnt = x_cnt + 4'd1;
                if (x_cnt == 4'd8) begin
                    x_data = x_acc;
                    x_fin  = (x_acc == i_term);
                    x_emit = 1'b1;
                    x_acc  = 8'd0;
                    x_cnt  = 4'd0;
                    x_done = x_fin;
                end
            end
        end
    end

    assign can_load = !r_closed && (r_len < LEN_W'(MSG_DEPTH));

    always_comb begin
        n_len    = r_len;
        n_closed = r_closed;
        n_pos    = r_pos;
        n_acc    = r_acc;
        n_nb     = r_nb;
        n_done   = r_done;
        if (i_accept) begin
            case (cmd)
                CMD_LOAD: begin
                    if (can_load) begin
                        n_len = r_len + LEN_W'(1);
                        if (i_msg_byte == i_term) begin
                            n_closed = 1'b1;
                        end
                    end
                end
                CMD_CLEAR: begin
                    n_len    = '0;
                    n_closed = 1'b0;
                end
                CMD_PIXEL: begin
                    if (i_mode == MODE_EMBED) begin
                        n_pos = new_pos;
                        if (i_frame_start) begin
                            n_acc  = 8'd0;
                            n_nb   = 3'd0;
                            n_done = 1'b0;
                        end
                    end else begin
                        n_pos  = pos0;
                        n_acc  = x_acc;
                        n_nb   = x_cnt[2:0];
                        n_done = x_done;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_closed <= 1'b0;
            r_pos    <= '0;
            r_acc    <= 8'd0;
            r_nb     <= 3'd0;
            r_done   <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_closed <= n_closed;
            r_pos    <= n_pos;
            r_acc    <= n_acc;
            r_nb     <= n_nb;
            r_done   <= n_done;
        end
    end

    // Bank requests: write on load, read both neighbouring bytes on an embed pixel.
    always_comb begin
        o_ram.we_even    = i_accept && (cmd == CMD_LOAD) && can_load && !r_len[0];
        o_ram.we_odd     = i_accept && (cmd == CMD_LOAD) && can_load && r_len[0];
        o_ram.waddr      = r_len[MSG_AW-1:1];
        o_ram.wdata      = i_msg_byte;
        o_ram.re         = i_accept && (cmd == CMD_PIXEL) && (i_mode == MODE_EMBED);
        o_ram.raddr_even = idx_p1[MSG_AW-1:1];
        o_ram.raddr_odd  = idx[MSG_AW-1:1];
    end

    always_comb begin
        o_s1.kind  = (i_mode == MODE_EMBED) ? KIND_PIXEL : KIND_BYTE;
        o_s1.en    = en;
        o_s1.off   = pos0[2:0];
        o_s1.idx0  = idx[0];
        o_s1.red   = i_pix_red;
        o_s1.green = i_pix_green;
        o_s1.blue  = i_pix_blue;
        o_s1.data  = x_data;
        o_s1.fin   = (i_mode == MODE_EMBED) ? (new_pos >= total) : x_fin;
        o_emit     = (cmd == CMD_PIXEL) && ((i_mode == MODE_EMBED) || x_emit);
    end

endmodule

// ===== sv/lsbse_embed.sv =====
module lsbse_embed (
    input  lsbse_pkg::t_s1  i_s1,
    input  logic [7:0]      i_even,
    input  logic [7:0]      i_odd,
    output lsbse_pkg::t_res o_res
);
    import lsbse_pkg::*;

    logic [15:0] word;
    logic [7:0]  lo, hi;
    logic [3:0]  sel0, sel1, sel2;

    always_comb begin
        lo   = i_s1.idx0 ? i_odd : i_even;
        hi   = i_s1.idx0 ? i_even : i_odd;
        word = {hi, lo};
        sel0 = {1'b0, i_s1.off};
        sel1 = sel0 + 4'd1;
        sel2 = sel0 + 4'd2;
        if (i_s1.kind == KIND_PIXEL) begin
            o_res.kind  = KIND_PIXEL;
            o_res.red   = i_s1.en[0] ? {i_s1.red[7:1], word[sel0]} : i_s1.red;
            o_res.green = i_s1.en[1] ? {i_s1.green[7:1], word[sel1]} : i_s1.green;
            o_res.blue  = i_s1.en[2] ? {i_s1.blue[7:1], word[sel2]} : i_s1.blue;
            o_res.data  = 8'd0;
        end else begin
            o_res.kind  = KIND_BYTE;
            o_res.red   = 8'd0;
            o_res.green = 8'd0;
            o_res.blue  = 8'd0;
            o_res.data  = i_s1.data;
        end
        o_res.fin = i_s1.fin;
    end

endmodule

// ===== sv/lsb_pixel_stego_embed_extract_top.sv =====
// LSB steganography over an RGB pixel stream. Load a message with load requests (kept up
// to and including the first terminator byte, at most 256 bytes), then send pixel requests:
// in embed mode each pixel leaves with the next three message bits in the low bits of red,
// green and blue, least significant bit first, and passes unchanged once the bits run out;
// in extract mode the low bits are gathered into bytes and each completed byte is emitted
// until the terminator has gone out. A frame-start flag on a pixel restarts the bit position
// and byte assembly. One request is taken every clock while o_in_stall is low; a result
// passes through the registered read of the message store (two banks, even and odd bytes,
// so the two bytes a pixel can straddle come out in the same cycle) and then the output
// register. Load, clear and unused requests, and extract pixels that complete no
// byte, give no result. Change mode or terminator only while the block is idle.
`include "lsb_pixel_stego_embed_extract_top_assert.svh"

module lsb_pixel_stego_embed_extract_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_msg_byte,
    input  logic [7:0]  i_pix_red,
    input  logic [7:0]  i_pix_green,
    input  logic [7:0]  i_pix_blue,
    input  logic        i_frame_start,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_byte,
    output logic        o_finished,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lsbse_pkg::*;

    logic       r_mode;
    logic [7:0] r_term;
    logic       cfg_wr;

    logic       r_s1_valid;
    t_s1        r_s1, n_s1;
    logic       r_out_valid;
    t_res       r_out, n_res;

    logic       out_free, s1_free, accept, emit;
    t_ram_req   ram;
    logic [7:0] even_q, odd_q;

    // Configuration: word address picks the register, low address bits are ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_TERM) ? {24'd0, r_term} : {31'd0, r_mode};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_EMBED;
            r_term <= TERM_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MODE) begin
                r_mode <= pwdata[0];
            end else begin
                r_term <= pwdata[7:0];
            end
        end
    end

    // Handshake: the output register frees the result stage, which frees the request side.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_free    = !r_s1_valid || out_free;
    assign o_in_stall = !s1_free;
    assign accept     = i_in_valid && s1_free;

    lsbse_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_cmd         (i_cmd),
        .i_msg_byte    (i_msg_byte),
        .i_pix_red     (i_pix_red),
        .i_pix_green   (i_pix_green),
        .i_pix_blue    (i_pix_blue),
        .i_frame_start (i_frame_start),
        .i_mode        (r_mode),
        .i_term        (r_term),
        .o_s1          (n_s1),
        .o_emit        (emit),
        .o_ram         (ram)
    );

    // Message store, even byte addresses.
    lsbse_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram_even (
        .i_clk   (i_clk),
        .i_we    (ram.we_even),
        .i_waddr (ram.waddr),
        .i_wdata (ram.wdata),
        .i_re    (ram.re),
        .i_raddr (ram.raddr_even),
        .o_rdata (even_q)
    );

    // Message store, odd byte addresses.
    lsbse_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram_odd (
        .i_clk   (i_clk),
        .i_we    (ram.we_odd),
        .i_waddr (ram.waddr),
        .i_wdata (ram.wdata),
        .i_re    (ram.re),
        .i_raddr (ram.raddr_odd),
        .o_rdata (odd_q)
    );

    lsbse_embed u_embed (
        .i_s1   (r_s1),
        .i_even (even_q),
        .i_odd  (odd_q),
        .o_res  (n_res)
    );

    // Advance valid flags; drop stage-one slots that produced nothing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= accept && emit;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload: hold while stalled.
    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1 <= n_s1;
        end
        if (out_free) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out.kind;
    assign o_out_red   = r_out.red;
    assign o_out_green = r_out.green;
    assign o_out_blue  = r_out.blue;
    assign o_out_byte  = r_out.data;
    assign o_finished  = r_out.fin;

    `LSBSE_ASSERT_IMP(a_stall_needs_full_pipe, o_in_stall,
        r_s1_valid && r_out_valid && i_out_stall,
        "request stalled with room in the pipeline")
    `LSBSE_ASSERT_NEXT(a_result_kept, r_out_valid && i_out_stall, r_out_valid,
        "stalled result lost")
    `LSBSE_ASSERT_IMP(a_byte_has_no_pixel, r_out_valid && r_out.kind == KIND_BYTE,
        r_out.red == 8'd0 && r_out.green == 8'd0 && r_out.blue == 8'd0,
        "recovered byte carries pixel data")

endmodule

// ===== tb/sv/lsb_pixel_stego_embed_extract_top_tb.sv =====
module lsb_pixel_stego_embed_extract_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsbse_pkg::*;

    // Share of cycles in which each side holds off, in percent.
    localparam int IDLE_PCT   = 29;
    // Number of random requests, counted from the start of the random traffic.
    localparam int RAND_ITEMS = 120;

    // ------------------------------------------------------------------
    // DUT signals, every input known from time zero
    // ------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_cmd         = CMD_NONE;
    logic [7:0]  i_msg_byte    = 8'h00;
    logic [7:0]  i_pix_red     = 8'h00;
    logic [7:0]  i_pix_green   = 8'h00;
    logic [7:0]  i_pix_blue    = 8'h00;
    logic        i_frame_start = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic        o_kind;
    logic [7:0]  o_out_red;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_blue;
    logic [7:0]  o_out_byte;
    logic        o_finished;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = 3'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // ------------------------------------------------------------------
    // Scoreboard state and the testbench's own copy of the block's state
    // ------------------------------------------------------------------
    int   idle_pct  = IDLE_PCT;   // sender hold-off chance
    int   stall_pct = IDLE_PCT;   // receiver stall chance
    int   n_fail    = 0;
    int   n_sent    = 0;
    t_res awaited[$];             // pixels and recovered bytes still to come out

    logic [7:0] msg_mem [MSG_DEPTH];
    int         msg_len     = 0;
    logic       load_shut   = 1'b0;
    int         bit_pos     = 0;
    logic [7:0] acc_byte    = 8'h00;
    int         acc_count   = 0;
    logic       recover_end = 1'b0;
    logic       cur_mode    = MODE_EMBED;
    logic [7:0] cur_term    = TERM_RESET;

    lsb_pixel_stego_embed_extract_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_msg_byte    (i_msg_byte),
        .i_pix_red     (i_pix_red),
        .i_pix_green   (i_pix_green),
        .i_pix_blue    (i_pix_blue),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_out_byte    (o_out_byte),
        .o_finished    (o_finished),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Replace the low bit of one channel with the next message bit, while any remain.
    function automatic logic [7:0] hide_bit(logic [7:0] chan, int total);
        if (bit_pos < total) begin
            chan[0] = msg_mem[bit_pos / 8][bit_pos % 8];
            bit_pos++;
        end
        return chan;
    endfunction

    // Advance the state by one accepted request and queue whatever it yields.
    function automatic void predict_stego(t_cmd cmd, logic [7:0] mb, logic [7:0] r, g, b,
                                          logic fs);
        int         total;
        logic [2:0] lsbs;
        t_res       res;
        case (cmd)
            CMD_LOAD: begin
                // drop the byte once the terminator is in or the store is full
                if (!load_shut && msg_len < MSG_DEPTH) begin
                    msg_mem[msg_len] = mb;
                    msg_len++;
                    if (mb == cur_term)
                        load_shut = 1'b1;
                end
            end
            CMD_CLEAR: begin
                // keep bit position and byte assembly as they are
                msg_len   = 0;
                load_shut = 1'b0;
            end
            CMD_PIXEL: begin
                if (fs) begin
                    bit_pos     = 0;
                    acc_byte    = 8'h00;
                    acc_count   = 0;
                    recover_end = 1'b0;
                end
                if (cur_mode == MODE_EMBED) begin
                    total     = msg_len * 8;
                    res.kind  = KIND_PIXEL;
                    res.red   = hide_bit(r, total);
                    res.green = hide_bit(g, total);
                    res.blue  = hide_bit(b, total);
                    res.data  = 8'h00;
                    res.fin   = (bit_pos >= total);
                    awaited.push_back(res);
                end else begin
                    lsbs = {b[0], g[0], r[0]};
                    // stop gathering as soon as the terminator has gone out
                    for (int k = 0; k < 3; k++) begin
                        if (!recover_end) begin
                            acc_byte[acc_count] = lsbs[k];
                            acc_count++;
                            if (acc_count == 8) begin
                                res.kind    = KIND_BYTE;
                                res.red     = 8'h00;
                                res.green   = 8'h00;
                                res.blue    = 8'h00;
                                res.data    = acc_byte;
                                res.fin     = (acc_byte == cur_term);
                                recover_end = res.fin;
                                awaited.push_back(res);
                                acc_byte    = 8'h00;
                                acc_count   = 0;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void note_fail(string msg);
        n_fail++;
        if (n_fail <= 10)
            $display("%s", msg);
    endfunction

    function automatic void push_byte(ref logic q[$], input logic [7:0] v);
        for (int k = 0; k < 8; k++)
            q.push_back(v[k]);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall, and check every result taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited.size() == 0) begin
                note_fail($sformatf(
                    "unexpected result: kind=%0d rgb=%02h/%02h/%02h byte=%02h fin=%0d",
                    o_kind, o_out_red, o_out_green, o_out_blue, o_out_byte, o_finished));
            end else begin
                e = awaited.pop_front();
                if (o_kind !== e.kind || o_out_red !== e.red || o_out_green !== e.green ||
                    o_out_blue !== e.blue || o_out_byte !== e.data || o_finished !== e.fin) begin
                    note_fail($sformatf({"mismatch: expected kind=%0d rgb=%02h/%02h/%02h ",
                                         "byte=%02h fin=%0d, got kind=%0d rgb=%02h/%02h/%02h ",
                                         "byte=%02h fin=%0d"},
                                        e.kind, e.red, e.green, e.blue, e.data, e.fin,
                                        o_kind, o_out_red, o_out_green, o_out_blue, o_out_byte,
                                        o_finished));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request, hold it until taken, then predict its effect.
    task automatic send_req(t_cmd cmd, logic [7:0] mb, logic [7:0] r, g, b, logic fs);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_msg_byte    <= mb;
        i_pix_red     <= r;
        i_pix_green   <= g;
        i_pix_blue    <= b;
        i_frame_start <= fs;
        do
            @(posedge i_clk);
        while (o_in_stall);
        n_sent++;
        predict_stego(cmd, mb, r, g, b, fs);
    endtask

    task automatic send_noise();
        send_req(t_cmd'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 1'($urandom));
    endtask

    task automatic send_pixels(int n, logic fs_first);
        for (int p = 0; p < n; p++)
            send_req(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     fs_first && p == 0);
    endtask

    // Carry a bit stream in pixel low bits, three to a pixel, random upper bits and padding.
    task automatic send_bits(logic fs_first, logic q[$]);
        logic [7:0] ch [3];
        for (int p = 0; p < q.size(); p += 3) begin
            for (int c = 0; c < 3; c++) begin
                ch[c] = 8'($urandom);
                if (p + c < q.size())
                    ch[c][0] = q[p + c];
            end
            send_req(CMD_PIXEL, 8'($urandom), ch[0], ch[1], ch[2], fs_first && p == 0);
        end
    endtask

    // Drop valid and wait until the block has nothing left in flight.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge i_clk);
        // cover pixels that complete no byte, still in the pipe
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(logic idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MODE)
            cur_mode = val[0];
        else
            cur_term = val[7:0];
        @(posedge i_clk);
    endtask

    task automatic set_config(logic mode, logic [7:0] term);
        drain_results();
        apb_write(REG_MODE, {31'd0, mode});
        apb_write(REG_TERM, {24'd0, term});
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset the store is empty: pixels pass untouched and report finished.
    task automatic test_embed_empty();
        send_req(CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        send_req(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_req(CMD_NONE,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_req(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    endtask

    // Embed with the reset terminator; a load after it is ignored, the tail passes through.
    task automatic test_embed_message();
        send_req(CMD_LOAD, 8'h00,      8'h00, 8'h00, 8'h00, 1'b0);
        send_req(CMD_LOAD, 8'hFF,      8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_req(CMD_LOAD, TERM_RESET, 8'h00, 8'h00, 8'h00, 1'b0);
        send_req(CMD_LOAD, 8'h11,      8'h00, 8'h00, 8'h00, 1'b0);
        // alternate all-zero and all-one pixels so each hidden bit shows in both senses
        for (int p = 0; p < 9; p++) begin
            if (p % 2 == 0)
                send_req(CMD_PIXEL, 8'h00, 8'hFF, 8'hFF, 8'hFF, p == 0);
            else
                send_req(CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        end
        // restart mid stream
        send_req(CMD_PIXEL, 8'h00, 8'hFE, 8'h01, 8'h80, 1'b1);
    endtask

    // Recover bytes; terminator ends on the first bit of a pixel, partial bits are dropped.
    task automatic test_extract_message();
        logic stream[$];
        set_config(MODE_EXTRACT, 8'hC3);
        push_byte(stream, 8'h00);
        push_byte(stream, 8'hC3);
        send_bits(1'b1, stream);
        // silent after the terminator until the next frame start
        send_pixels(1, 1'b0);
        stream.delete();
        push_byte(stream, 8'hFF);
        stream.push_back(1'b1);
        send_bits(1'b1, stream);
        stream.delete();
        push_byte(stream, 8'h5A);
        send_bits(1'b1, stream);
    endtask

    // Fill past capacity and embed the whole store in one unbroken burst.
    task automatic test_full_store();
        set_config(MODE_EMBED, 8'h00);
        idle_pct  = 0;
        stall_pct = 0;
        send_req(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        repeat (MSG_DEPTH + 2)
            send_req(CMD_LOAD, 8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom),
                     8'($urandom), 1'($urandom));
        send_pixels(MSG_DEPTH * 8 / 3 + 3, 1'b1);
        idle_pct  = IDLE_PCT;
        stall_pct = IDLE_PCT;
        // a short message after a clear reads rewritten entries only
        send_req(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_req(CMD_LOAD, 8'($urandom_range(1, 255)), 8'h00, 8'h00, 8'h00, 1'b0);
        send_req(CMD_LOAD, 8'($urandom_range(1, 255)), 8'h00, 8'h00, 8'h00, 1'b0);
        send_pixels(7, 1'b1);
    endtask

    // Mostly well-formed messages and hidden streams with random content, some noise.
    task automatic test_random_traffic();
        int         start_n;
        int         n_bytes;
        int         n_pix;
        logic       mode;
        logic [7:0] term;
        logic       stream[$];
        start_n = n_sent;
        while (n_sent - start_n < RAND_ITEMS) begin
            mode = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0:       term = 8'h00;
                1:       term = 8'hFF;
                2:       term = TERM_RESET;
                default: term = 8'($urandom);
            endcase
            set_config(mode, term);
            repeat (2) begin
                repeat ($urandom_range(0, 1)) send_noise();
                if (mode == MODE_EMBED) begin
                    // sometimes keep the old message and carry on from the shared position
                    if ($urandom_range(0, 3) != 0) begin
                        send_req(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                                 8'($urandom), 1'($urandom));
                        n_bytes = $urandom_range(0, 10);
                        repeat (n_bytes)
                            send_req(CMD_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
                                     8'($urandom), 1'($urandom));
                        if ($urandom_range(0, 9) < 7)
                            send_req(CMD_LOAD, term, 8'($urandom), 8'($urandom),
                                     8'($urandom), 1'($urandom));
                        repeat ($urandom_range(0, 2))
                            send_req(CMD_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
                                     8'($urandom), 1'($urandom));
                    end
                    n_pix = msg_len * 8 / 3;
                    if (n_pix > 40)
                        n_pix = 40;
                    send_pixels(n_pix + $urandom_range(1, 6), $urandom_range(0, 4) != 0);
                end else begin
                    stream.delete();
                    // shift byte boundaries off the pixel grid now and then
                    repeat ($urandom_range(0, 2)) stream.push_back(1'($urandom));
                    n_bytes = $urandom_range(1, 6);
                    repeat (n_bytes) push_byte(stream, 8'($urandom));
                    if ($urandom_range(0, 3) != 0)
                        push_byte(stream, term);
                    send_bits($urandom_range(0, 5) != 0, stream);
                    send_pixels($urandom_range(0, 2), 1'b0);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int guard;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_embed_empty();
        test_embed_message();
        test_extract_message();
        test_full_store();
        test_random_traffic();

        // drain, with a bound, then let the pipeline settle
        i_in_valid <= 1'b0;
        guard = 0;
        while (awaited.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        if (awaited.size() != 0)
            note_fail($sformatf("%0d expected results never arrived", awaited.size()));

        if (n_fail == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #1ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
